### design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

### design/ccb_pkg.sv
// Shared types and constants of the console CPU bus.
package ccb_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] PPU_NONE  = 2'd0;
  localparam logic [1:0] PPU_READ  = 2'd1;
  localparam logic [1:0] PPU_PEEK  = 2'd2;
  localparam logic [1:0] PPU_WRITE = 2'd3;

  localparam logic [15:0] RAM_TOP   = 16'h1FFF;
  localparam logic [15:0] PPU_TOP   = 16'h3FFF;
  localparam logic [15:0] DMA_START = 16'h4014;
  localparam logic [15:0] PAD0_ADDR = 16'h4016;
  localparam logic [15:0] PAD1_ADDR = 16'h4017;

  localparam logic [2:0] PH_DMA_READ  = 3'd0;
  localparam logic [2:0] PH_DMA_WRITE = 3'd3;
  localparam logic [2:0] PH_LAST      = 3'd5;

  // Beat in flight between the decode stage and the response stage.
  typedef struct packed {
    logic [7:0]  rdata;
    logic        ram_sel;
    logic        latch_ram;
    logic        cpu_step;
    logic [1:0]  ppu_op;
    logic [2:0]  ppu_reg;
    logic [7:0]  ppu_wdata;
    logic        oam_write;
    logic [7:0]  oam_index;
    logic [7:0]  oam_data;
    logic        nmi_out;
    logic        dma_busy;
    logic        dma_read;
    logic [15:0] dma_src_addr;
  } stage_t;

  // DMA latch update once the RAM byte of a DMA read arrives.
  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } latch_wr_t;

  typedef struct packed {
    logic clearing;
    logic dma_active;
  } status_t;

endpackage

### design/ccb_if.sv
// Valid/ready channel interfaces for bus requests and bus results.
interface ccb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] addr;
  logic [7:0]  wdata;
  logic        read_only;
  logic        cart_hit;
  logic [7:0]  cart_rdata;
  logic [7:0]  ppu_rdata;
  logic [7:0]  pad_buttons;
  logic        ppu_nmi;

  modport source (output valid, op, addr, wdata, read_only, cart_hit, cart_rdata,
                  ppu_rdata, pad_buttons, ppu_nmi, input ready);
  modport sink (input valid, op, addr, wdata, read_only, cart_hit, cart_rdata,
                ppu_rdata, pad_buttons, ppu_nmi, output ready);
endinterface

interface ccb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rdata;
  logic        cpu_step;
  logic [1:0]  ppu_op;
  logic [2:0]  ppu_reg;
  logic [7:0]  ppu_wdata;
  logic        oam_write;
  logic [7:0]  oam_index;
  logic [7:0]  oam_data;
  logic        nmi_out;
  logic        dma_busy;
  logic        dma_read;
  logic [15:0] dma_src_addr;

  modport source (output valid, rdata, cpu_step, ppu_op, ppu_reg, ppu_wdata, oam_write,
                  oam_index, oam_data, nmi_out, dma_busy, dma_read, dma_src_addr,
                  input ready);
  modport sink (input valid, rdata, cpu_step, ppu_op, ppu_reg, ppu_wdata, oam_write,
                oam_index, oam_data, nmi_out, dma_busy, dma_read, dma_src_addr,
                output ready);
endinterface

### design/ccb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ccb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### design/ccb_decode.sv
// Decode stage: address decode, bus state, DMA sequencing and work RAM access.
module ccb_decode #(
  parameter int RAM_DEPTH = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ccb_in_if.sink                in_i,
  input  logic                  s1_free_i,
  input  ccb_pkg::latch_wr_t    latch_wr_i,
  output logic                  load_o,
  output ccb_pkg::stage_t       stage_o,
  output ccb_pkg::status_t      status_o,
  output logic                  ram_we_o,
  output logic [$clog2(RAM_DEPTH)-1:0] ram_waddr_o,
  output logic [7:0]            ram_wdata_o,
  output logic                  ram_re_o,
  output logic [$clog2(RAM_DEPTH)-1:0] ram_raddr_o
);

  localparam int IW = $clog2(RAM_DEPTH);

  logic          clearing_q;
  logic [IW-1:0] clr_q;
  logic [7:0]    pad_q [2];
  logic [7:0]    pad_d [2];
  logic [7:0]    page_q, page_d;
  logic [7:0]    offset_q, offset_d;
  logic [7:0]    latch_q, latch_d;
  logic          active_q, active_d;
  logic          wait_q, wait_d;
  logic [2:0]    phase_q, phase_d;

  logic          acc;
  logic          is_rd, is_wr, is_tick;
  logic          dma_rd, dma_wr;
  logic          rd_en;
  logic [15:0]   rd_addr;
  logic          rd_ram, rd_ppu, rd_pad;
  logic [7:0]    rd_val;
  logic          wr_ram;

  assign in_i.ready = ~clearing_q & s1_free_i;
  assign acc        = in_i.valid & in_i.ready;
  assign load_o     = acc;
  assign status_o   = '{clearing: clearing_q, dma_active: active_q};

  always_comb begin
    is_rd   = (in_i.op == ccb_pkg::OP_READ);
    is_wr   = (in_i.op == ccb_pkg::OP_WRITE);
    is_tick = (in_i.op == ccb_pkg::OP_TICK);
    dma_rd  = is_tick & (phase_q == ccb_pkg::PH_DMA_READ) & active_q & ~wait_q;
    dma_wr  = is_tick & (phase_q == ccb_pkg::PH_DMA_WRITE) & active_q & ~wait_q;
    rd_en   = is_rd | dma_rd;
    rd_addr = is_rd ? in_i.addr : {page_q, offset_q};

    rd_ram = ~in_i.cart_hit & (rd_addr <= ccb_pkg::RAM_TOP);
    rd_ppu = ~in_i.cart_hit & ~rd_ram & (rd_addr <= ccb_pkg::PPU_TOP);
    rd_pad = ~in_i.cart_hit & ((rd_addr == ccb_pkg::PAD0_ADDR) |
                               (rd_addr == ccb_pkg::PAD1_ADDR));

    if (in_i.cart_hit) begin
      rd_val = in_i.cart_rdata;
    end else if (rd_ppu) begin
      rd_val = in_i.ppu_rdata;
    end else if (rd_pad) begin
      rd_val = {7'd0, pad_q[rd_addr[0]][7]};
    end else begin
      rd_val = 8'd0;
    end

    wr_ram = is_wr & ~in_i.cart_hit & (in_i.addr <= ccb_pkg::RAM_TOP);

    pad_d[0] = pad_q[0];
    pad_d[1] = pad_q[1];
    page_d   = page_q;
    offset_d = offset_q;
    active_d = active_q;
    wait_d   = wait_q;
    phase_d  = phase_q;
    latch_d  = latch_wr_i.en ? latch_wr_i.data : latch_q;

    stage_o = '0;
    stage_o.rdata     = is_rd ? rd_val : 8'd0;
    stage_o.ram_sel   = is_rd & rd_ram;
    stage_o.latch_ram = dma_rd & rd_ram;
    stage_o.nmi_out   = is_tick & in_i.ppu_nmi;
    stage_o.dma_read  = dma_rd;
    stage_o.dma_src_addr = dma_rd ? rd_addr : 16'd0;

    if (rd_en & rd_ppu) begin
      stage_o.ppu_op  = (is_rd & in_i.read_only) ? ccb_pkg::PPU_PEEK : ccb_pkg::PPU_READ;
      stage_o.ppu_reg = rd_addr[2:0];
    end
    if (rd_en & rd_pad) begin
      pad_d[rd_addr[0]] = {pad_q[rd_addr[0]][6:0], 1'b0};
    end
    if (acc & dma_rd & ~rd_ram) begin
      latch_d = rd_val;
    end

    if (is_wr & ~in_i.cart_hit & ~wr_ram) begin
      if (in_i.addr <= ccb_pkg::PPU_TOP) begin
        stage_o.ppu_op    = ccb_pkg::PPU_WRITE;
        stage_o.ppu_reg   = in_i.addr[2:0];
        stage_o.ppu_wdata = in_i.wdata;
      end else if (in_i.addr == ccb_pkg::DMA_START) begin
        page_d   = in_i.wdata;
        offset_d = 8'd0;
        active_d = 1'b1;
      end else if ((in_i.addr == ccb_pkg::PAD0_ADDR) |
                   (in_i.addr == ccb_pkg::PAD1_ADDR)) begin
        pad_d[in_i.addr[0]] = in_i.pad_buttons;
      end
    end

    if (is_tick) begin
      phase_d = (phase_q == ccb_pkg::PH_LAST) ? 3'd0 : phase_q + 3'd1;
      if ((phase_q == ccb_pkg::PH_DMA_READ) | (phase_q == ccb_pkg::PH_DMA_WRITE)) begin
        if (!active_q) begin
          stage_o.cpu_step = 1'b1;
        end else if (wait_q) begin
          // The transfer starts only after an odd phase has gone by.
          if (phase_q[0]) begin
            wait_d = 1'b0;
          end
        end else if (dma_wr) begin
          stage_o.oam_write = 1'b1;
          stage_o.oam_index = offset_q;
          stage_o.oam_data  = latch_q;
          offset_d = offset_q + 8'd1;
          if (offset_q == 8'hFF) begin
            active_d = 1'b0;
            wait_d   = 1'b1;
          end
        end
      end
    end

    stage_o.dma_busy = active_d;
  end

  // The RAM is swept to zero after reset; items wait until the sweep ends.
  always_comb begin
    if (clearing_q) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = clr_q;
      ram_wdata_o = 8'd0;
    end else begin
      ram_we_o    = acc & wr_ram;
      ram_waddr_o = in_i.addr[IW-1:0];
      ram_wdata_o = in_i.wdata;
    end
    ram_re_o    = acc & rd_en & rd_ram;
    ram_raddr_o = rd_addr[IW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
      pad_q[0]   <= 8'd0;
      pad_q[1]   <= 8'd0;
      page_q     <= 8'd0;
      offset_q   <= 8'd0;
      latch_q    <= 8'd0;
      active_q   <= 1'b0;
      wait_q     <= 1'b1;
      phase_q    <= 3'd0;
    end else begin
      if (clearing_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == IW'(RAM_DEPTH - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      latch_q <= latch_d;
      if (acc) begin
        pad_q[0] <= pad_d[0];
        pad_q[1] <= pad_d[1];
        page_q   <= page_d;
        offset_q <= offset_d;
        active_q <= active_d;
        wait_q   <= wait_d;
        phase_q  <= phase_d;
      end
    end
  end

endmodule

### design/ccb_resp.sv
// Response stage: merges RAM read data and holds the result in an output register.
module ccb_resp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  ccb_pkg::stage_t    stage_i,
  input  logic [7:0]         ram_rdata_i,
  output logic               s1_free_o,
  output ccb_pkg::latch_wr_t latch_wr_o,
  ccb_out_if.source          out_o
);

  logic            s1_valid_q;
  ccb_pkg::stage_t s1_q;
  logic            out_valid_q;
  ccb_pkg::stage_t out_q;
  ccb_pkg::stage_t merged;
  logic            s1_adv;

  assign s1_adv    = s1_valid_q & (~out_valid_q | out_o.ready);
  assign s1_free_o = ~s1_valid_q | s1_adv;

  // RAM read data stays put until the next read, so it is valid while the beat waits.
  always_comb begin
    merged = s1_q;
    if (s1_q.ram_sel) begin
      merged.rdata = ram_rdata_i;
    end
  end

  assign latch_wr_o = '{en: s1_valid_q & s1_q.latch_ram, data: ram_rdata_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_q <= stage_i;
    end
    if (s1_adv) begin
      out_q <= merged;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.rdata        = out_q.rdata;
  assign out_o.cpu_step     = out_q.cpu_step;
  assign out_o.ppu_op       = out_q.ppu_op;
  assign out_o.ppu_reg      = out_q.ppu_reg;
  assign out_o.ppu_wdata    = out_q.ppu_wdata;
  assign out_o.oam_write    = out_q.oam_write;
  assign out_o.oam_index    = out_q.oam_index;
  assign out_o.oam_data     = out_q.oam_data;
  assign out_o.nmi_out      = out_q.nmi_out;
  assign out_o.dma_busy     = out_q.dma_busy;
  assign out_o.dma_read     = out_q.dma_read;
  assign out_o.dma_src_addr = out_q.dma_src_addr;

endmodule

### design/console_cpu_bus_with_sprite_dma.sv
// Top level of the console CPU bus with sprite DMA.
//
// Requests arrive on in_i: a CPU read, a CPU write or a system tick, one per
// beat. Each request yields exactly one result beat on out_o, in order.
// Work RAM is a synchronous memory of RAM_DEPTH bytes (a power of two); an
// address below 0x2000 selects the entry given by its low address bits.
// A result passes the response stage and then the output register. A new
// request is taken every cycle unless in_i drops ready: state registers update
// at decode; the RAM byte of a read joins the result in the response stage.
// After reset the work RAM is swept to zero, one entry per cycle, so in_i
// stays not ready until the sweep ends; the DMA waits for an odd phase and
// the tick phase restarts at zero.
// When out_o stalls, one result sits in the output register and one in the
// response stage; in_i then drops ready until the output register drains.
module console_cpu_bus_with_sprite_dma #(
  parameter int RAM_DEPTH = 2048
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ccb_in_if.sink    in_i,
  ccb_out_if.source out_o
);

  `include "assert_macros.svh"

  localparam int IW = $clog2(RAM_DEPTH);

  logic               load;
  logic               s1_free;
  ccb_pkg::stage_t    stage;
  ccb_pkg::status_t   status;
  ccb_pkg::latch_wr_t latch_wr;
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [7:0]         ram_wdata;
  logic               ram_re;
  logic [IW-1:0]      ram_raddr;
  logic [7:0]         ram_rdata;

  ccb_decode #(
    .RAM_DEPTH(RAM_DEPTH)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .s1_free_i   (s1_free),
    .latch_wr_i  (latch_wr),
    .load_o      (load),
    .stage_o     (stage),
    .status_o    (status),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr)
  );

  ccb_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ccb_resp u_resp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .stage_i     (stage),
    .ram_rdata_i (ram_rdata),
    .s1_free_o   (s1_free),
    .latch_wr_o  (latch_wr),
    .out_o       (out_o)
  );

  `ASSERT_NEVER(a_no_beat_while_clearing, clk_i, rst_ni, load && status.clearing)
  `ASSERT_ALWAYS(a_dma_read_keeps_busy, clk_i, rst_ni, out_o.valid && out_o.dma_read |-> out_o.dma_busy)
  `ASSERT_NEVER(a_cpu_or_dma, clk_i, rst_ni, out_o.valid && out_o.cpu_step && (out_o.dma_read || out_o.oam_write))
  `ASSERT_ALWAYS(a_dma_read_needs_active, clk_i, rst_ni, load && stage.dma_read |-> status.dma_active)

endmodule

### tb/sv/console_cpu_bus_with_sprite_dma_tb.sv
// Self-checking testbench of the console CPU bus with sprite DMA.
`timescale 1ns / 1ps

module console_cpu_bus_with_sprite_dma_tb;

  localparam int RAM_DEPTH = 2048;
  // The RAM sweep after reset holds off the first beat until the sweep ends.
  localparam int STALL_LIMIT = 4 * RAM_DEPTH + 400;
  localparam int MAX_REPORTS = 10;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [15:0] PPU_BASE = 16'h2000;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        read_only;
    logic        cart_hit;
    logic [7:0]  cart_rdata;
    logic [7:0]  ppu_rdata;
    logic [7:0]  pad_buttons;
    logic        ppu_nmi;
  } bus_req_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic        cpu_step;
    logic [1:0]  ppu_op;
    logic [2:0]  ppu_reg;
    logic [7:0]  ppu_wdata;
    logic        oam_write;
    logic [7:0]  oam_index;
    logic [7:0]  oam_data;
    logic        nmi_out;
    logic        dma_busy;
    logic        dma_read;
    logic [15:0] dma_src_addr;
  } bus_res_t;

  logic clk_i;
  logic rst_ni;

  ccb_in_if  req_if ();
  ccb_out_if res_if ();

  console_cpu_bus_with_sprite_dma #(.RAM_DEPTH(RAM_DEPTH)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (res_if)
  );

  // Shadow state of the bus.
  logic [7:0] ram_shadow [RAM_DEPTH];
  logic [7:0] pad_latch [2];
  logic [7:0] sprite_page;
  logic [7:0] sprite_offset;
  logic [7:0] sprite_byte;
  logic       sprite_active;
  logic       sprite_align_wait;
  logic [2:0] tick_ph;

  bus_res_t bus_results_due [$];
  int       failures = 0;
  int       result_beats = 0;
  int       quiet_cycles = 0;
  bit       steady = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void reset_shadow();
    foreach (ram_shadow[i]) ram_shadow[i] = 8'h00;
    pad_latch[0] = 8'h00;
    pad_latch[1] = 8'h00;
    sprite_page = 8'h00;
    sprite_offset = 8'h00;
    sprite_byte = 8'h00;
    sprite_active = 1'b0;
    sprite_align_wait = 1'b1;
    tick_ph = 3'd0;
  endfunction

  // Read decode shared by CPU reads and sprite DMA reads.
  function automatic logic [7:0] bus_read_byte(input logic [15:0] a, input logic peek,
                                               input logic hit, input logic [7:0] crd,
                                               input logic [7:0] prd, inout bus_res_t res);
    logic [7:0] val;
    logic       port;
    val = 8'h00;
    if (hit) begin
      val = crd;
    end else if (a <= ccb_pkg::RAM_TOP) begin
      val = ram_shadow[a % RAM_DEPTH];
    end else if (a <= ccb_pkg::PPU_TOP) begin
      res.ppu_op = peek ? ccb_pkg::PPU_PEEK : ccb_pkg::PPU_READ;
      res.ppu_reg = a[2:0];
      val = prd;
    end else if (a == ccb_pkg::PAD0_ADDR || a == ccb_pkg::PAD1_ADDR) begin
      port = a[0];
      val = {7'd0, pad_latch[port][7]};
      pad_latch[port] = pad_latch[port] << 1;
    end
    return val;
  endfunction

  function automatic bus_res_t predict_bus_beat(input bus_req_t r);
    bus_res_t   res;
    logic [7:0] rd;
    res = '0;
    case (r.op)
      ccb_pkg::OP_READ: begin
        rd = bus_read_byte(r.addr, r.read_only, r.cart_hit, r.cart_rdata, r.ppu_rdata, res);
        res.rdata = rd;
      end
      ccb_pkg::OP_WRITE: begin
        if (!r.cart_hit) begin
          if (r.addr <= ccb_pkg::RAM_TOP) begin
            ram_shadow[r.addr % RAM_DEPTH] = r.wdata;
          end else if (r.addr <= ccb_pkg::PPU_TOP) begin
            res.ppu_op = ccb_pkg::PPU_WRITE;
            res.ppu_reg = r.addr[2:0];
            res.ppu_wdata = r.wdata;
          end else if (r.addr == ccb_pkg::DMA_START) begin
            sprite_page = r.wdata;
            sprite_offset = 8'h00;
            sprite_active = 1'b1;
          end else if (r.addr == ccb_pkg::PAD0_ADDR || r.addr == ccb_pkg::PAD1_ADDR) begin
            pad_latch[r.addr[0]] = r.pad_buttons;
          end
        end
      end
      ccb_pkg::OP_TICK: begin
        if (tick_ph == ccb_pkg::PH_DMA_READ || tick_ph == ccb_pkg::PH_DMA_WRITE) begin
          if (!sprite_active) begin
            res.cpu_step = 1'b1;
          end else if (sprite_align_wait) begin
            // The transfer only starts once an odd phase has passed.
            if (tick_ph == ccb_pkg::PH_DMA_WRITE) sprite_align_wait = 1'b0;
          end else if (tick_ph == ccb_pkg::PH_DMA_READ) begin
            res.dma_read = 1'b1;
            res.dma_src_addr = {sprite_page, sprite_offset};
            rd = bus_read_byte({sprite_page, sprite_offset}, 1'b0, r.cart_hit, r.cart_rdata,
                               r.ppu_rdata, res);
            sprite_byte = rd;
          end else begin
            res.oam_write = 1'b1;
            res.oam_index = sprite_offset;
            res.oam_data = sprite_byte;
            sprite_offset = sprite_offset + 8'd1;
            if (sprite_offset == 8'h00) begin
              sprite_active = 1'b0;
              sprite_align_wait = 1'b1;
            end
          end
        end
        res.nmi_out = r.ppu_nmi;
        tick_ph = (tick_ph == ccb_pkg::PH_LAST) ? 3'd0 : tick_ph + 3'd1;
      end
      default: ;
    endcase
    res.dma_busy = sprite_active;
    return res;
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want)
      note_failure($sformatf("result beat %0d: %s expected %h, got %h",
                             result_beats, field, want, got));
  endtask

  always @(posedge clk_i) begin : beat_check
    bus_res_t seen;
    bus_res_t want;
    bus_req_t req;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        seen.rdata = res_if.rdata;
        seen.cpu_step = res_if.cpu_step;
        seen.ppu_op = res_if.ppu_op;
        seen.ppu_reg = res_if.ppu_reg;
        seen.ppu_wdata = res_if.ppu_wdata;
        seen.oam_write = res_if.oam_write;
        seen.oam_index = res_if.oam_index;
        seen.oam_data = res_if.oam_data;
        seen.nmi_out = res_if.nmi_out;
        seen.dma_busy = res_if.dma_busy;
        seen.dma_read = res_if.dma_read;
        seen.dma_src_addr = res_if.dma_src_addr;
        if (bus_results_due.size() == 0) begin
          note_failure($sformatf("result beat %0d arrived with nothing expected",
                                 result_beats));
        end else begin
          want = bus_results_due.pop_front();
          check_field("rdata", want.rdata, seen.rdata);
          check_field("cpu_step", want.cpu_step, seen.cpu_step);
          check_field("ppu_op", want.ppu_op, seen.ppu_op);
          check_field("ppu_reg", want.ppu_reg, seen.ppu_reg);
          check_field("ppu_wdata", want.ppu_wdata, seen.ppu_wdata);
          check_field("oam_write", want.oam_write, seen.oam_write);
          check_field("oam_index", want.oam_index, seen.oam_index);
          check_field("oam_data", want.oam_data, seen.oam_data);
          check_field("nmi_out", want.nmi_out, seen.nmi_out);
          check_field("dma_busy", want.dma_busy, seen.dma_busy);
          check_field("dma_read", want.dma_read, seen.dma_read);
          check_field("dma_src_addr", want.dma_src_addr, seen.dma_src_addr);
        end
        result_beats++;
      end
      if (req_if.valid && req_if.ready) begin
        req.op = req_if.op;
        req.addr = req_if.addr;
        req.wdata = req_if.wdata;
        req.read_only = req_if.read_only;
        req.cart_hit = req_if.cart_hit;
        req.cart_rdata = req_if.cart_rdata;
        req.ppu_rdata = req_if.ppu_rdata;
        req.pad_buttons = req_if.pad_buttons;
        req.ppu_nmi = req_if.ppu_nmi;
        bus_results_due.push_back(predict_bus_beat(req));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("No beat accepted for %0d cycles", quiet_cycles);
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  // Result side back-pressure: random stall bursts until the closing part.
  initial begin : result_ready_driver
    int n;
    @(negedge clk_i);
    forever begin
      if (!steady && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 16);
        res_if.ready <= 1'b0;
      end else begin
        n = $urandom_range(1, 20);
        res_if.ready <= 1'b1;
      end
      repeat (n) @(negedge clk_i);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input bus_req_t r);
    bit taken;
    req_if.valid <= 1'b1;
    req_if.op <= r.op;
    req_if.addr <= r.addr;
    req_if.wdata <= r.wdata;
    req_if.read_only <= r.read_only;
    req_if.cart_hit <= r.cart_hit;
    req_if.cart_rdata <= r.cart_rdata;
    req_if.ppu_rdata <= r.ppu_rdata;
    req_if.pad_buttons <= r.pad_buttons;
    req_if.ppu_nmi <= r.ppu_nmi;
    do begin
      @(posedge clk_i);
      taken = req_if.ready;
      @(negedge clk_i);
    end while (!taken);
  endtask

  task automatic sender_gap();
    int n;
    if (!steady && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 16);
      req_if.valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  function automatic bus_req_t plain_req(input logic [1:0] op, input logic [15:0] addr,
                                         input logic [7:0] wdata);
    bus_req_t r;
    r = '0;
    r.op = op;
    r.addr = addr;
    r.wdata = wdata;
    return r;
  endfunction

  function automatic bus_req_t rand_req(input bit dma_start_ok, input int tick_pct);
    bus_req_t r;
    int       pick;
    if ($urandom_range(0, 99) < tick_pct) r.op = ccb_pkg::OP_TICK;
    else r.op = $urandom_range(0, 1) ? ccb_pkg::OP_WRITE : ccb_pkg::OP_READ;
    if ($urandom_range(0, 49) == 0) r.op = OP_UNUSED;
    r.wdata = 8'($urandom_range(0, 255));
    r.read_only = 1'($urandom_range(0, 1));
    r.cart_hit = ($urandom_range(0, 7) == 0);
    r.cart_rdata = 8'($urandom_range(0, 255));
    r.ppu_rdata = 8'($urandom_range(0, 255));
    r.pad_buttons = 8'($urandom_range(0, 255));
    r.ppu_nmi = ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 35) r.addr = 16'($urandom_range(0, ccb_pkg::RAM_TOP));
    else if (pick < 55) r.addr = 16'($urandom_range(PPU_BASE, ccb_pkg::PPU_TOP));
    else if (pick < 75) r.addr = $urandom_range(0, 1) ? ccb_pkg::PAD1_ADDR : ccb_pkg::PAD0_ADDR;
    else if (pick < 78) r.addr = ccb_pkg::DMA_START;
    else if (pick < 90) r.addr = 16'($urandom_range(16'h4000, 16'h401F));
    else r.addr = 16'($urandom_range(0, 16'hFFFF));
    if (!dma_start_ok && r.op == ccb_pkg::OP_WRITE && r.addr == ccb_pkg::DMA_START)
      r.op = ccb_pkg::OP_READ;
    return r;
  endfunction

  task automatic test_work_ram();
    send_beat(plain_req(ccb_pkg::OP_WRITE, 16'h0000, 8'hA5));
    send_beat(plain_req(ccb_pkg::OP_WRITE, ccb_pkg::RAM_TOP, 8'h5A));
    // The first two addresses below alias entries written above through the mirror.
    send_beat(plain_req(ccb_pkg::OP_READ, 16'h0800, 8'h00));
    send_beat(plain_req(ccb_pkg::OP_READ, 16'h07FF, 8'h00));
    send_beat(plain_req(ccb_pkg::OP_READ, 16'h1234, 8'h00));
  endtask

  task automatic test_ppu_strobes();
    bus_req_t r;
    send_beat(plain_req(ccb_pkg::OP_WRITE, PPU_BASE, 8'hFF));
    send_beat(plain_req(ccb_pkg::OP_WRITE, ccb_pkg::PPU_TOP, 8'h00));
    r = plain_req(ccb_pkg::OP_READ, 16'h2002, 8'h00);
    r.ppu_rdata = 8'h80;
    send_beat(r);
    r = plain_req(ccb_pkg::OP_READ, ccb_pkg::PPU_TOP, 8'h00);
    r.read_only = 1'b1;
    r.ppu_rdata = 8'hFF;
    send_beat(r);
  endtask

  task automatic test_pads();
    bus_req_t r;
    r = plain_req(ccb_pkg::OP_WRITE, ccb_pkg::PAD0_ADDR, 8'h00);
    r.pad_buttons = 8'hA5;
    send_beat(r);
    r = plain_req(ccb_pkg::OP_WRITE, ccb_pkg::PAD1_ADDR, 8'h00);
    r.pad_buttons = 8'hFF;
    send_beat(r);
    send_beat(plain_req(ccb_pkg::OP_READ, ccb_pkg::PAD0_ADDR, 8'h00));
    send_beat(plain_req(ccb_pkg::OP_READ, ccb_pkg::PAD0_ADDR, 8'h00));
    send_beat(plain_req(ccb_pkg::OP_READ, ccb_pkg::PAD1_ADDR, 8'h00));
  endtask

  task automatic test_cart_claim();
    bus_req_t r;
    r = plain_req(ccb_pkg::OP_READ, 16'h0000, 8'h00);
    r.cart_hit = 1'b1;
    r.cart_rdata = 8'hC3;
    send_beat(r);
    r = plain_req(ccb_pkg::OP_WRITE, 16'h0000, 8'h3C);
    r.cart_hit = 1'b1;
    send_beat(r);
    send_beat(plain_req(ccb_pkg::OP_READ, 16'h0000, 8'h00));
  endtask

  task automatic test_odd_cases();
    bus_req_t r;
    send_beat(plain_req(ccb_pkg::OP_READ, 16'h5000, 8'h00));
    send_beat(plain_req(ccb_pkg::OP_READ, 16'hFFFF, 8'h00));
    send_beat(plain_req(ccb_pkg::OP_WRITE, 16'h4015, 8'hFF));
    r = plain_req(OP_UNUSED, 16'h0000, 8'hFF);
    r.ppu_nmi = 1'b1;
    send_beat(r);
    // A request outside a tick must not forward the interrupt.
    r = plain_req(ccb_pkg::OP_READ, 16'h0001, 8'h00);
    r.ppu_nmi = 1'b1;
    send_beat(r);
    r = plain_req(ccb_pkg::OP_TICK, 16'h0000, 8'h00);
    r.ppu_nmi = 1'b1;
    send_beat(r);
    send_beat(plain_req(ccb_pkg::OP_TICK, 16'h0000, 8'h00));
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) begin
      send_beat(rand_req(1'b1, 40));
      sender_gap();
    end
  endtask

  // Runs a sprite transfer for a bounded number of beats, optionally restarting it midway.
  task automatic test_sprite_dma(input logic [7:0] page, input logic [7:0] restart_page,
                                 input int count);
    bus_req_t r;
    int       sent;
    if ({page, 8'h00} <= ccb_pkg::RAM_TOP) begin
      repeat (24) begin
        send_beat(plain_req(ccb_pkg::OP_WRITE, {page, 8'($urandom_range(0, 15))},
                            8'($urandom_range(0, 255))));
        sender_gap();
      end
    end
    send_beat(plain_req(ccb_pkg::OP_WRITE, ccb_pkg::DMA_START, page));
    sent = 0;
    while (sprite_active && sent < count) begin
      r = rand_req(1'b0, 85);
      if (sent == count / 2 && restart_page != page)
        r = plain_req(ccb_pkg::OP_WRITE, ccb_pkg::DMA_START, restart_page);
      send_beat(r);
      sender_gap();
      sent++;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.op = ccb_pkg::OP_READ;
    req_if.addr = 16'h0000;
    req_if.wdata = 8'h00;
    req_if.read_only = 1'b0;
    req_if.cart_hit = 1'b0;
    req_if.cart_rdata = 8'h00;
    req_if.ppu_rdata = 8'h00;
    req_if.pad_buttons = 8'h00;
    req_if.ppu_nmi = 1'b0;
    res_if.ready = 1'b0;
    reset_shadow();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_work_ram();
    test_ppu_strobes();
    test_pads();
    test_cart_claim();
    test_odd_cases();
    test_random_traffic(110);
    test_sprite_dma(8'h0B, 8'h21, 100);
    test_sprite_dma(8'h40, 8'h40, 170);
    steady = 1'b1;
    test_random_traffic(40);

    req_if.valid <= 1'b0;
    while (bus_results_due.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
